[design/sdf_pkg.sv]
// Shared types and constants for the signed decimal field formatter.
// No dependencies; imported by every design file but sdf_checker.
`default_nettype none

package sdf_pkg;

	// Fixed sizes of the value path.
	localparam int ValueW    = 32;
	localparam int NumDigits = 10;
	localparam int BcdW      = 4 * NumDigits;

	// ASCII codes the field is built from.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;

	// Packed decimal digits, most significant digit in the top nibble.
	typedef logic [BcdW-1:0] sdf_bcd_t;

	// Character counts of each region of the field, handed to the emitter.
	typedef struct packed {
		logic [5:0] lead;
		logic       sign_en;
		logic [7:0] sign_ch;
		logic [5:0] zeros;
		logic [3:0] ndig;
		logic [5:0] trail;
	} sdf_plan_t;

endpackage

`default_nettype wire

[design/sdf_bcd.sv]
// Bit-serial binary to decimal converter (shift and add-3), followed by a
// digit-serial alignment pass that finds the digit count. Uses sdf_pkg.
`default_nettype none

module sdf_bcd (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [sdf_pkg::ValueW-1:0]    mag,
	output logic                               done,
	output sdf_pkg::sdf_bcd_t                  digits,
	output logic [3:0]                         ndig
);
	import sdf_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_CONV, B_ALIGN} bcd_state_t;

	bcd_state_t          state_q;
	logic [5:0]          cnt_q;
	sdf_bcd_t            bcd_q;
	logic [ValueW-1:0]   bin_q;
	logic                done_q;
	sdf_bcd_t            adj;
	logic                top_zero;

	// Add-3 correction on every digit before the next shift.
	always_comb begin
		int i;
		for (i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_zero = (bcd_q[BcdW-1 -: 4] == 4'd0);

	// One magnitude bit per cycle during conversion, then one digit per cycle
	// of left shift until the top digit is nonzero or every digit is shifted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= 6'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (start) begin
						bin_q   <= mag;
						bcd_q   <= '0;
						cnt_q   <= 6'd0;
						state_q <= B_CONV;
					end
				end
				B_CONV: begin
					bcd_q <= {adj[BcdW-2:0], bin_q[ValueW-1]};
					bin_q <= bin_q << 1;
					if (cnt_q == 6'(ValueW - 1)) begin
						cnt_q   <= 6'd0;
						state_q <= B_ALIGN;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				B_ALIGN: begin
					if (!top_zero || cnt_q == 6'(NumDigits)) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						bcd_q <= bcd_q << 4;
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;
	assign ndig   = 4'(NumDigits) - cnt_q[3:0];

endmodule

`default_nettype wire

[design/sdf_emit.sv]
// Character sequencer: walks the padding, sign, zero and digit regions of
// a planned field and emits one ASCII character per cycle. Uses sdf_pkg.
`default_nettype none

module sdf_emit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  sdf_pkg::sdf_plan_t        plan,
	input  sdf_pkg::sdf_bcd_t         digits,
	output logic                      strobe,
	output logic [7:0]                out_char,
	output logic                      last_char,
	output logic                      done
);
	import sdf_pkg::*;

	typedef enum logic [2:0] {
		E_IDLE, E_PICK, E_LEAD, E_SIGN, E_ZERO, E_DIGIT, E_TRAIL
	} emit_state_t;

	emit_state_t state_q;
	sdf_plan_t   plan_q;
	sdf_bcd_t    dig_q;
	logic [5:0]  cnt_q;
	logic        strobe_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        done_q;

	emit_state_t nx_lead, nx_sign, nx_zero, nx_digit, nx_trail, nxt;
	logic [5:0]  nxt_cnt;
	logic [7:0]  cur_char;
	logic        phase_end;

	// First nonempty region at or after each point of the field.
	always_comb begin
		nx_trail = (plan_q.trail != 6'd0) ? E_TRAIL : E_IDLE;
		nx_digit = (plan_q.ndig != 4'd0) ? E_DIGIT : nx_trail;
		nx_zero  = (plan_q.zeros != 6'd0) ? E_ZERO : nx_digit;
		nx_sign  = plan_q.sign_en ? E_SIGN : nx_zero;
		nx_lead  = (plan_q.lead != 6'd0) ? E_LEAD : nx_sign;
	end

	// Region that follows the current one, and its character count.
	always_comb begin
		case (state_q)
			E_PICK:  nxt = nx_lead;
			E_LEAD:  nxt = nx_sign;
			E_SIGN:  nxt = nx_zero;
			E_ZERO:  nxt = nx_digit;
			E_DIGIT: nxt = nx_trail;
			default: nxt = E_IDLE;
		endcase
		case (nxt)
			E_LEAD:  nxt_cnt = plan_q.lead;
			E_SIGN:  nxt_cnt = 6'd1;
			E_ZERO:  nxt_cnt = plan_q.zeros;
			E_DIGIT: nxt_cnt = {2'b00, plan_q.ndig};
			E_TRAIL: nxt_cnt = plan_q.trail;
			default: nxt_cnt = 6'd0;
		endcase
	end

	// Character of the current region.
	always_comb begin
		case (state_q)
			E_SIGN:  cur_char = plan_q.sign_ch;
			E_ZERO:  cur_char = CHAR_ZERO;
			E_DIGIT: cur_char = CHAR_ZERO | {4'h0, dig_q[BcdW-1 -: 4]};
			default: cur_char = CHAR_SPACE;
		endcase
	end

	assign phase_end = (cnt_q == 6'd1);

	// Sequencer state and registered character output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			cnt_q    <= 6'd0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (start) begin
						plan_q  <= plan;
						dig_q   <= digits;
						state_q <= E_PICK;
					end
				end
				E_PICK: begin
					state_q <= nxt;
					cnt_q   <= nxt_cnt;
					if (nxt == E_IDLE) begin
						done_q <= 1'b1;
					end
				end
				E_LEAD, E_SIGN, E_ZERO, E_DIGIT, E_TRAIL: begin
					strobe_q <= 1'b1;
					char_q   <= cur_char;
					if (state_q == E_DIGIT) begin
						dig_q <= dig_q << 4;
					end
					if (phase_end) begin
						state_q <= nxt;
						cnt_q   <= nxt_cnt;
						if (nxt == E_IDLE) begin
							last_q <= 1'b1;
							done_q <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign out_char  = char_q;
	assign last_char = last_q;
	assign done      = done_q;

endmodule

`default_nettype wire

[design/signed_decimal_field_formatter.sv]
// Formats a signed 32-bit value as a printf-style decimal field, one ASCII
// character per strobe. An item is taken when start is high and busy is low;
// busy stays high until the last character has been sent. Each item goes
// through the bit-serial conversion, an alignment pass that shifts out
// the leading zero digits one per cycle, planning, then emission of one
// character per cycle. The receiver must take every character as it is
// strobed; last_char marks the final one. An empty field strobes nothing.
// Depends on sdf_pkg, sdf_bcd and sdf_emit.
`default_nettype none

module signed_decimal_field_formatter #(
	parameter int MAX_FIELD = 63
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         field_width,
	input  wire logic signed [6:0]  min_digits,
	input  wire logic               left_align,
	input  wire logic               zero_fill,
	input  wire logic               force_plus,
	input  wire logic               space_sign,
	output logic                    strobe,
	output logic [7:0]              out_char,
	output logic                    last_char
);
	import sdf_pkg::*;

	localparam logic [5:0] MaxField = 6'(MAX_FIELD);
	localparam logic [5:0] PrecMax  = 6'(MAX_FIELD - 1);

	typedef enum logic [1:0] {T_IDLE, T_CONV, T_PLAN, T_EMIT} top_state_t;

	top_state_t        state_q;
	logic              accept;
	logic [ValueW-1:0] value_u;
	logic [ValueW-1:0] mag;

	logic              neg_q, left_q, zfill_q, plus_q, space_q;
	logic [5:0]        width_q;
	logic [6:0]        prec_q;
	logic [3:0]        dc_s1;
	logic [5:0]        body_s1;

	logic              bcd_done;
	sdf_bcd_t          bcd_digits;
	logic [3:0]        bcd_ndig;
	logic              emit_done;

	logic              has_prec;
	logic [5:0]        prec_c;
	logic [3:0]        dc;
	logic [5:0]        body;

	logic              sign_en;
	logic              zero_mode;
	logic [5:0]        width_c;
	logic [6:0]        total;
	logic [6:0]        pad;
	logic [6:0]        zeros7;
	sdf_plan_t         plan;

	assign accept  = start && (state_q == T_IDLE);
	assign busy    = (state_q != T_IDLE);
	assign value_u = $unsigned(value);
	assign mag     = value_u[ValueW-1] ? (~value_u + 32'd1) : value_u;

	// Digit count and body length once the conversion is done.
	always_comb begin
		has_prec = !prec_q[6];
		prec_c   = (prec_q[5:0] > PrecMax) ? PrecMax : prec_q[5:0];
		if (bcd_ndig == 4'd0 && !(has_prec && prec_q == 7'd0)) begin
			dc = 4'd1;
		end else begin
			dc = bcd_ndig;
		end
		if (has_prec && prec_c > {2'b00, dc}) begin
			body = prec_c;
		end else begin
			body = {2'b00, dc};
		end
	end

	// Padding and region counts of the field.
	always_comb begin
		sign_en   = neg_q || plus_q || space_q;
		zero_mode = !left_q && zfill_q && (prec_q[6] || prec_q == 7'd0);
		width_c   = (width_q > MaxField) ? MaxField : width_q;
		total     = {1'b0, body_s1} + {6'd0, sign_en};
		pad       = ({1'b0, width_c} > total) ? ({1'b0, width_c} - total) : 7'd0;
		zeros7    = ({1'b0, body_s1} - {3'b000, dc_s1}) + (zero_mode ? pad : 7'd0);

		plan.lead    = (!left_q && !zero_mode) ? pad[5:0] : 6'd0;
		plan.sign_en = sign_en;
		if (neg_q) begin
			plan.sign_ch = CHAR_MINUS;
		end else if (plus_q) begin
			plan.sign_ch = CHAR_PLUS;
		end else begin
			plan.sign_ch = CHAR_SPACE;
		end
		plan.zeros = zeros7[5:0];
		plan.ndig  = dc_s1;
		plan.trail = left_q ? pad[5:0] : 6'd0;
	end

	// Transaction control and captured field settings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						neg_q   <= value_u[ValueW-1];
						width_q <= field_width;
						prec_q  <= $unsigned(min_digits);
						left_q  <= left_align;
						zfill_q <= zero_fill;
						plus_q  <= force_plus;
						space_q <= space_sign;
						state_q <= T_CONV;
					end
				end
				T_CONV: begin
					if (bcd_done) begin
						dc_s1   <= dc;
						body_s1 <= body;
						state_q <= T_PLAN;
					end
				end
				T_PLAN: begin
					state_q <= T_EMIT;
				end
				T_EMIT: begin
					if (emit_done) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	sdf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.done   (bcd_done),
		.digits (bcd_digits),
		.ndig   (bcd_ndig)
	);

	sdf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == T_PLAN),
		.plan      (plan),
		.digits    (bcd_digits),
		.strobe    (strobe),
		.out_char  (out_char),
		.last_char (last_char),
		.done      (emit_done)
	);

endmodule

`default_nettype wire

[design/sdf_checker.sv]
// Port-level checks for the signed decimal field formatter, attached to
// the top level by the bind statement at the end of this file.
`default_nettype none

module sdf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [7:0] out_char,
	input wire logic       last_char
);

	// An accepted transaction holds the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted transaction");

	// Characters only follow a cycle in which the block was busy.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !strobe)
		else $error("character strobed while the block was idle");

	// The final character closes the field.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_char) |=> !strobe)
		else $error("character strobed after the final one");

	// Only padding, sign and digit characters are produced.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (out_char == 8'h20 || out_char == 8'h2B || out_char == 8'h2D ||
			(out_char >= 8'h30 && out_char <= 8'h39)))
		else $error("character outside the decimal field set");

endmodule

bind signed_decimal_field_formatter sdf_checker u_sdf_checker (.*);

`default_nettype wire
